// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the ARP cache RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

// ===== hw/rtl/arpc_pkg.sv =====
// Types and constants of the ARP cache responder.
// No dependencies; used by the controller, the datapath and the top level.
package arpc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;

    localparam logic [15:0] OP_REQUEST = 16'd1;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_REPLY = 2'd1,
        ACT_HIT   = 2'd2,
        ACT_MISS  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic        cmd;
        logic [15:0] opcode;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
    } t_item;

    typedef struct packed {
        t_action     action;
        logic [47:0] dest_mac;
        logic [31:0] dest_ip;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture the input item
        logic scan_start;  // rewind the table scan
        logic scan_en;     // issue one table read, advance the compare stage
        logic finish;      // load the result register and, for a learn item, update the table
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic hit;         // compared entry matches the key
        logic last;        // compared entry is the last one
        logic out_busy;    // result register full and not taken this cycle
    } t_status;

endpackage

// ===== hw/rtl/arp_cache_responder_unit.sv =====
// Top level of the ARP cache with responder.
// Depends on arpc_pkg, arpc_ctrl and arpc_datapath.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-------------------------------
//  s_axis   | in        | i_s_axis_tvalid/o_..._tready | tdata 128 b, tuser = cmd
//  m_axis   | out       | o_m_axis_tvalid/i_..._tready | tdata 80 b, tuser = action
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | index 2 b, data 48 b
//
// Scan: the table is read in order, one entry read per cycle through a registered
// read port, and the scan stops at the first matching entry or, on a miss, after
// the last of the ENTRIES entries.
// Reset: synchronous, active low; it clears the valid bits of the table, the fill
// slot and own_ip at once, so no clearing pass is needed.
// Stalls: a result waits in the output register; the next item is accepted
// meanwhile and its scan runs, and only its finish step waits for the register.
// Configuration writes are always taken and must arrive while the block is idle.
module arp_cache_responder_unit
    import arpc_pkg::*;
#(
    parameter int ENTRIES = 16
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input items.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // opcode[15:0], sender_ip[47:16], sender_mac[95:48], target_ip[127:96]
    input  logic [127:0]         i_s_axis_tdata,
    // cmd[0]
    input  logic [0:0]           i_s_axis_tuser,
    // Result items.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // dest_mac[47:0], dest_ip[79:48]
    output logic [79:0]          o_m_axis_tdata,
    // action[1:0]
    output logic [1:0]           o_m_axis_tuser,
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [47:0]          i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;
    t_item   w_item;
    t_result w_result;

    // Unpack the input transaction.
    assign w_item.cmd        = i_s_axis_tuser[0];
    assign w_item.opcode     = i_s_axis_tdata[15:0];
    assign w_item.sender_ip  = i_s_axis_tdata[47:16];
    assign w_item.sender_mac = i_s_axis_tdata[95:48];
    assign w_item.target_ip  = i_s_axis_tdata[127:96];

    // Configuration takes effect at once; never stall it.
    assign o_cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (w_cmd),
        .i_status  (w_status)
    );

    arpc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_item      (w_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (w_result)
    );

    // Pack the result transaction.
    assign o_m_axis_tdata = {w_result.dest_ip, w_result.dest_mac};
    assign o_m_axis_tuser = w_result.action;

endmodule

// ===== hw/rtl/arpc_ctrl.sv =====
// Sequencer of the ARP cache: accept, scan the table, finish.
// Depends on arpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.hit || i_status.last) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready        = 1'b0;
        o_cmd            = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready        = 1'b1;
                o_cmd.load       = i_s_valid;
                o_cmd.scan_start = i_s_valid;
            end
            ST_SCAN: begin
                // Freeze the compare stage once the outcome is known.
                o_cmd.scan_en = !(i_status.hit || i_status.last);
            end
            ST_FIN: begin
                o_cmd.finish = !i_status.out_busy;
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

    `ASSERT_CLK(a_fin_holds_outcome, (r_state != ST_FIN) || i_status.hit || i_status.last,
        "scan outcome lost while finishing")
    `ASSERT_CLK(a_finish_needs_room, !o_cmd.finish || !i_status.out_busy,
        "result register overwritten")
    `ASSERT_CLK(a_no_scan_when_idle, (r_state != ST_IDLE) || !o_cmd.scan_en,
        "table scanned while idle")

endmodule

// ===== hw/rtl/arpc_datapath.sv =====
// Datapath of the ARP cache: item registers, entry table, compare, result register.
// Depends on arpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arpc_datapath
    import arpc_pkg::*;
#(
    parameter int ENTRIES = 16
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  t_item                i_item,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [47:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_result              o_result
);

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

    // Item and configuration.
    t_item       r_item;
    logic [31:0] r_own_ip;

    // Entry table.
    logic [31:0]        r_mem_ip  [ENTRIES];
    logic [47:0]        r_mem_mac [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [IDXW-1:0]    r_next_slot;

    // Scan pipeline: read stage then compare stage.
    logic [CNTW-1:0] r_scan_idx;
    logic [IDXW-1:0] r_cmp_idx;
    logic            r_cmp_live;
    logic [31:0]     r_rd_ip;
    logic [47:0]     r_rd_mac;
    logic            r_rd_vld;

    // Result register.
    t_result r_out;
    logic    r_out_valid;

    logic [31:0]     w_key;
    logic [31:0]     w_entry_ip;
    logic [47:0]     w_entry_mac;
    logic            w_hit;
    logic            w_wr_en;
    logic [IDXW-1:0] w_wr_idx;
    logic [IDXW-1:0] w_rd_idx;
    t_result         w_res;

    assign w_key       = r_item.cmd ? r_item.target_ip : r_item.sender_ip;
    assign w_rd_idx    = r_scan_idx[IDXW-1:0];
    // An entry never written reads as cleared.
    assign w_entry_ip  = r_rd_vld ? r_rd_ip  : 32'd0;
    assign w_entry_mac = r_rd_vld ? r_rd_mac : 48'd0;
    assign w_hit       = r_cmp_live && (w_entry_ip == w_key);
    assign w_wr_en     = i_cmd.finish && !r_item.cmd;
    assign w_wr_idx    = w_hit ? r_cmp_idx : r_next_slot;

    always_comb begin
        w_res = '0;
        if (r_item.cmd) begin
            w_res.dest_ip = r_item.target_ip;
            if (w_hit) begin
                w_res.action   = ACT_HIT;
                w_res.dest_mac = w_entry_mac;
            end else begin
                w_res.action   = ACT_MISS;
                w_res.dest_mac = '1;
            end
        end else if (r_item.opcode == OP_REQUEST && r_item.target_ip == r_own_ip) begin
            w_res.action   = ACT_REPLY;
            w_res.dest_mac = r_item.sender_mac;
            w_res.dest_ip  = r_item.sender_ip;
        end
    end

    // Payload registers and table storage.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (w_wr_en) begin
            r_mem_ip[w_wr_idx]  <= w_key;
            r_mem_mac[w_wr_idx] <= r_item.sender_mac;
        end
        if (i_cmd.scan_en) begin
            r_rd_ip   <= r_mem_ip[w_rd_idx];
            r_rd_mac  <= r_mem_mac[w_rd_idx];
            r_rd_vld  <= r_valid[w_rd_idx];
            r_cmp_idx <= w_rd_idx;
        end
        if (i_cmd.finish) begin
            r_out <= w_res;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip    <= 32'd0;
            r_valid     <= '0;
            r_next_slot <= '0;
            r_scan_idx  <= '0;
            r_cmp_live  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The own MAC register is accepted and dropped: no result field uses it.
            if (i_cfg_valid && i_cfg_index == CFG_OWN_IP) begin
                r_own_ip <= i_cfg_data[31:0];
            end
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_cmp_live <= 1'b0;
            end else if (i_cmd.scan_en) begin
                r_scan_idx <= r_scan_idx + CNTW'(1);
                r_cmp_live <= 1'b1;
            end
            if (w_wr_en) begin
                r_valid[w_wr_idx] <= 1'b1;
                if (!w_hit) begin
                    r_next_slot <= (r_next_slot == LAST_IDX) ? '0
                                                             : r_next_slot + IDXW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.hit      = w_hit;
    assign o_status.last     = r_cmp_live && (r_cmp_idx == LAST_IDX);
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_out;

    `ASSERT_NEXT(a_finish_sets_out, i_cmd.finish, r_out_valid,
        "result not presented after finish")
    `ASSERT_NEXT(a_lookup_keeps_slot, i_cmd.finish && r_item.cmd, $stable(r_next_slot),
        "lookup changed the fill slot")
    `ASSERT_NEXT(a_learn_hit_keeps_slot, w_wr_en && w_hit, $stable(r_next_slot),
        "matching update advanced the fill slot")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for arp_cache_responder_unit: learning, replies, lookups.
// Depends on arpc_pkg and the RTL; a small scoreboard class mirrors the ARP table.
module testbench;
    import arpc_pkg::*;

    localparam int          TABLE_DEPTH = 16;
    localparam int          POOL_SIZE   = 24;
    localparam int          PHASE_ITEMS = 350;
    localparam int          QUIET_LIMIT = 5000;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    // Mirror of the ARP table: predicts one response per accepted transaction
    // and checks the responses in order.
    class arp_table_mirror;
        logic [31:0] slot_ip  [TABLE_DEPTH];
        logic [47:0] slot_mac [TABLE_DEPTH];
        int unsigned fill_ptr;
        logic [31:0] station_ip;
        logic [47:0] station_mac;
        t_result     pending_responses [$];
        int          failures;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_ip[i]  = '0;
                slot_mac[i] = '0;
            end
            fill_ptr    = 0;
            station_ip  = '0;
            station_mac = '0;
            failures    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
            if (idx == CFG_OWN_IP) begin
                station_ip = data[31:0];
            end else if (idx == CFG_OWN_MAC) begin
                station_mac = data;
            end
        endfunction

        // Lowest slot holding ip, or TABLE_DEPTH when none does.
        function int lookup_slot(logic [31:0] ip);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_ip[i] == ip) return i;
            end
            return TABLE_DEPTH;
        endfunction

        function void predict_response(t_item it);
            t_result r;
            int      hit;
            r.action   = ACT_NONE;
            r.dest_mac = '0;
            r.dest_ip  = '0;
            if (it.cmd == 1'b0) begin
                // Always learn the sender; update in place or take the fill slot.
                hit = lookup_slot(it.sender_ip);
                if (hit < TABLE_DEPTH) begin
                    slot_mac[hit] = it.sender_mac;
                end else begin
                    slot_ip[fill_ptr]  = it.sender_ip;
                    slot_mac[fill_ptr] = it.sender_mac;
                    fill_ptr = (fill_ptr + 1) % TABLE_DEPTH;
                end
                if (it.opcode == OP_REQUEST && it.target_ip == station_ip) begin
                    r.action   = ACT_REPLY;
                    r.dest_mac = it.sender_mac;
                    r.dest_ip  = it.sender_ip;
                end
            end else begin
                hit = lookup_slot(it.target_ip);
                r.dest_ip = it.target_ip;
                if (hit < TABLE_DEPTH) begin
                    r.action   = ACT_HIT;
                    r.dest_mac = slot_mac[hit];
                end else begin
                    r.action   = ACT_MISS;
                    r.dest_mac = '1;
                end
            end
            pending_responses.push_back(r);
        endfunction

        function void check_response(logic [1:0] act, logic [47:0] mac, logic [31:0] ip);
            t_result want;
            if (pending_responses.size() == 0) begin
                if (failures < 10)
                    $display("unexpected response: action %0d mac %h ip %h", act, mac, ip);
                failures++;
                return;
            end
            want = pending_responses.pop_front();
            if (want.action !== act || want.dest_mac !== mac || want.dest_ip !== ip) begin
                if (failures < 10)
                    $display("response mismatch: expected action %0d mac %h ip %h, got %0d %h %h",
                             want.action, want.dest_mac, want.dest_ip, act, mac, ip);
                failures++;
            end
        endfunction
    endclass

    // Every input starts at a known value.
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // opcode[15:0], sender_ip[47:16], sender_mac[95:48], target_ip[127:96]
    logic [127:0]         i_s_axis_tdata  = '0;
    // cmd[0]
    logic [0:0]           i_s_axis_tuser  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // dest_mac[47:0], dest_ip[79:48]
    logic [79:0]          o_m_axis_tdata;
    // action[1:0]
    logic [1:0]           o_m_axis_tuser;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_OWN_IP;
    logic [47:0]          i_cfg_data      = '0;

    arp_table_mirror tracker;
    int              sender_idle_pct    = 0;
    int              receiver_stall_pct = 0;
    int              quiet_cycles       = 0;
    logic [31:0]     ip_pool [POOL_SIZE];

    arp_cache_responder_unit #(
        .ENTRIES (TABLE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: stall at random according to the current phase.
    always @(posedge i_clk) begin
        i_m_axis_tready <= (receiver_stall_pct == 0) ? 1'b1
                         : ($urandom_range(99) >= receiver_stall_pct);
    end

    // Check each response transaction; count cycles in which nothing moves.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_response(o_m_axis_tuser, o_m_axis_tdata[47:0], o_m_axis_tdata[79:48]);
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run when the block stops moving.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // Present one item, optionally after an idle gap, and hold it until accepted.
    task automatic send_item(t_item it);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {it.target_ip, it.sender_mac, it.sender_ip, it.opcode};
        i_s_axis_tuser  <= it.cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.predict_response(it);
    endtask

    task automatic send_packet(logic [15:0] op, logic [31:0] sip, logic [47:0] smac,
                               logic [31:0] tip);
        t_item it;
        it.cmd        = 1'b0;
        it.opcode     = op;
        it.sender_ip  = sip;
        it.sender_mac = smac;
        it.target_ip  = tip;
        send_item(it);
    endtask

    // Lookup with random content in the fields the block ignores.
    task automatic send_lookup(logic [31:0] tip);
        t_item       it;
        logic [31:0] r;
        r             = $urandom;
        it.cmd        = 1'b1;
        it.opcode     = r[15:0];
        it.sender_ip  = $urandom;
        it.sender_mac = rand48();
        it.target_ip  = tip;
        send_item(it);
    endtask

    // Drop valid and wait until every predicted response has come back.
    task automatic wait_responses();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly learn and lookup traffic over a small IP pool so that hits,
    // updates, replies and wraps keep happening; the rest is pure noise.
    function automatic t_item make_random_item();
        t_item       it;
        logic [31:0] r;
        int unsigned pick;
        r             = $urandom;
        pick          = $urandom_range(99);
        it.cmd        = 1'b0;
        it.opcode     = r[15:0];
        it.sender_ip  = $urandom;
        it.sender_mac = rand48();
        it.target_ip  = $urandom;
        if (pick < 45) begin
            it.sender_ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
            pick = $urandom_range(99);
            if (pick < 50) begin
                it.opcode = OP_REQUEST;
            end else if (pick < 85) begin
                it.opcode = OP_REPLY;
            end
            if ($urandom_range(1) == 1) begin
                it.target_ip = tracker.station_ip;
            end else if ($urandom_range(1) == 1) begin
                it.target_ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
            end
        end else if (pick < 85) begin
            it.cmd = 1'b1;
            if ($urandom_range(9) != 0) it.target_ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
            it.cmd = r[16];
        end
        return it;
    endfunction

    initial begin
        tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with own_ip at its reset value of zero.
        send_lookup(32'h0);                        // cleared entry hits, MAC zero
        send_lookup(32'hFFFF_FFFF);                // miss, broadcast
        send_packet(OP_REQUEST, 32'h0, '1, 32'h0); // learn IP zero into a cleared entry
        send_lookup(32'h0);
        send_packet(OP_REQUEST, 32'h0A00_0001, 48'h1234_5678_9ABC, 32'h0);
        send_lookup(32'h0);                        // next cleared entry now wins
        send_packet(OP_REPLY, 32'hFFFF_FFFF, 48'h0, 32'h0);
        send_packet(16'h0000, 32'h0A00_0002, 48'hAAAA_5555_AAAA, 32'h0);
        send_packet(16'hFFFF, 32'h0A00_0003, 48'h5555_AAAA_5555, 32'h0);
        send_packet(OP_REQUEST, 32'h0A00_0001, 48'hFEDC_BA98_7654, 32'h0A00_0001);
        send_lookup(32'h0A00_0001);
        wait_responses();

        write_register(CFG_OWN_IP, 48'hFFFF_FFFF_FFFF);
        write_register(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        send_packet(OP_REQUEST, 32'hC0A8_0001, 48'h0000_0000_0001, 32'hFFFF_FFFF);
        // Fill the rest of the table and wrap over the oldest slot.
        for (int k = 0; k < 12; k++)
            send_packet(OP_REPLY, 32'hC0A8_0010 + k, rand48(), 32'hFFFF_FFFF);
        send_lookup(32'h0A00_0001);
        send_lookup(32'h0);
        send_lookup(32'hC0A8_001B);
        wait_responses();

        // Random phases: each with its own idling and register settings.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                    write_register(CFG_OWN_IP, rand48());
                    write_register(CFG_OWN_MAC, 48'h0);
                end
                1: begin
                    sender_idle_pct = 53; receiver_stall_pct = 0;
                    write_register(CFG_OWN_IP, 48'h0);
                    write_register(CFG_OWN_MAC, rand48());
                end
                2: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 53;
                    write_register(CFG_OWN_IP, 48'hFFFF_FFFF_FFFF);
                    write_register(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
                end
                default: begin
                    sender_idle_pct = 19; receiver_stall_pct = 19;
                    write_register(CFG_OWN_IP, rand48());
                    write_register(CFG_OWN_MAC, rand48());
                end
            endcase
            // Fresh address pool; keep IP zero and our own IP in it.
            for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom;
            ip_pool[0] = 32'h0;
            ip_pool[1] = tracker.station_ip;
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(make_random_item());
            wait_responses();
        end

        // Let any stray response show up before the verdict.
        repeat (32) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_responses.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
